@@ rtl/core/ordinal_date_add_and_diff_unit_defines.svh @@
// Assertion macros shared by the ordinal date arithmetic RTL
`ifndef ORDINAL_DATE_ADD_AND_DIFF_UNIT_DEFINES_SVH
`define ORDINAL_DATE_ADD_AND_DIFF_UNIT_DEFINES_SVH

// Check a same-cycle implication on the block clock, off during reset
`define ODAD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check an implication that lands in the next cycle, off during reset
`define ODAD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/odad_pkg.sv @@
// Types, constants and microcode program of the ordinal date arithmetic unit
`default_nettype none

package odad_pkg;

   // Field widths
   localparam int YEAR_W = 15;
   localparam int DAY_W  = 9;
   localparam int OFF_W  = 24;
   localparam int CNT_W  = 25;
   localparam int ORD_W  = 27;   // signed day ordinal with room for the offset
   localparam int YR_W   = 16;   // working year, reaches one past the last year
   localparam int PRD_W  = 40;
   localparam int PC_W   = 5;

   // Calendar constants
   localparam logic [YR_W-1:0]         YEAR_TOP    = 16'd32767;
   localparam logic signed [ORD_W-1:0] DAYS_LIMIT  = 27'sd11968266;
   localparam logic [8:0]              YEAR_DAYS   = 9'd365;
   localparam logic [DAY_W-1:0]        MAX_DAY     = 9'd365;

   // Reciprocals: x/25 as (x*DIV25_RECIP)>>DIV25_SHIFT for x below 8217,
   // and an estimate of ordinal*400/146097 as (ord*EST_RECIP)>>EST_SHIFT
   localparam logic [12:0] DIV25_RECIP = 13'd5243;
   localparam int          DIV25_SHIFT = 17;
   localparam logic [15:0] EST_RECIP   = 16'd45935;
   localparam int          EST_SHIFT   = 24;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_YR_A,
      OP_YR_A1,
      OP_YR_B,
      OP_YR_B1,
      OP_YR_INC,
      OP_YR_DEC,
      OP_YR_EST,
      OP_EST_MUL,
      OP_DB_365,
      OP_DB_4,
      OP_DB_M100,
      OP_DB_S100,
      OP_DB_M400,
      OP_DB_A400,
      OP_ORD_A,
      OP_ORD_OFF,
      OP_AUX_B,
      OP_SET_ERR,
      OP_CNT,
      OP_DAY
   } op_type;

   typedef enum logic [3:0] {
      COND_ALWAYS,
      COND_DIFF,
      COND_ORD_NEG,
      COND_ORD_HIGH,
      COND_ORD_GE_ACC,
      COND_AUX_GE_ACC,
      COND_STAY,
      COND_YR_TOP,
      COND_ACC_LE_ORD
   } cond_type;

   typedef enum logic [2:0] {
      SEQ_NEXT,
      SEQ_BRANCH,
      SEQ_CALL,
      SEQ_RET,
      SEQ_DONE
   } seq_type;

   typedef struct packed {
      seq_type          seq;
      cond_type         cond;
      op_type           op;
      logic [PC_W-1:0]  target;
   } ucode_type;

   // Program labels
   localparam logic [PC_W-1:0] UA_START = 5'd0;
   localparam logic [PC_W-1:0] UA_DOWN  = 5'd6;
   localparam logic [PC_W-1:0] UA_UP    = 5'd9;
   localparam logic [PC_W-1:0] UA_FIN   = 5'd13;
   localparam logic [PC_W-1:0] UA_ERR   = 5'd15;
   localparam logic [PC_W-1:0] UA_DIFF  = 5'd16;
   localparam logic [PC_W-1:0] UA_DB    = 5'd25;

   // Control store. The routine at UA_DB leaves the days before year yr in acc.
   function automatic ucode_type ucode_word(input logic [PC_W-1:0] addr);
      ucode_type w;
      w = '{SEQ_NEXT, COND_ALWAYS, OP_NOP, UA_START};
      case (addr)
         // dispatch, load year A for both paths
         5'd0:  w = '{SEQ_BRANCH, COND_DIFF,       OP_YR_A,    UA_DIFF};
         // sum: ordinal of A plus offset, range check, year estimate
         5'd1:  w = '{SEQ_CALL,   COND_ALWAYS,     OP_NOP,     UA_DB};
         5'd2:  w = '{SEQ_NEXT,   COND_ALWAYS,     OP_ORD_A,   UA_START};
         5'd3:  w = '{SEQ_NEXT,   COND_ALWAYS,     OP_ORD_OFF, UA_START};
         5'd4:  w = '{SEQ_BRANCH, COND_ORD_NEG,    OP_EST_MUL, UA_ERR};
         5'd5:  w = '{SEQ_BRANCH, COND_ORD_HIGH,   OP_YR_EST,  UA_ERR};
         // step the year down while it starts after the ordinal
         5'd6:  w = '{SEQ_CALL,   COND_ALWAYS,     OP_NOP,     UA_DB};
         5'd7:  w = '{SEQ_BRANCH, COND_STAY,       OP_NOP,     UA_UP};
         5'd8:  w = '{SEQ_BRANCH, COND_ALWAYS,     OP_YR_DEC,  UA_DOWN};
         // step the year up while the next one starts at or before it
         5'd9:  w = '{SEQ_BRANCH, COND_YR_TOP,     OP_NOP,     UA_FIN};
         5'd10: w = '{SEQ_CALL,   COND_ALWAYS,     OP_YR_INC,  UA_DB};
         5'd11: w = '{SEQ_BRANCH, COND_ACC_LE_ORD, OP_NOP,     UA_UP};
         5'd12: w = '{SEQ_NEXT,   COND_ALWAYS,     OP_YR_DEC,  UA_START};
         5'd13: w = '{SEQ_CALL,   COND_ALWAYS,     OP_NOP,     UA_DB};
         5'd14: w = '{SEQ_DONE,   COND_ALWAYS,     OP_DAY,     UA_START};
         5'd15: w = '{SEQ_DONE,   COND_ALWAYS,     OP_SET_ERR, UA_START};
         // difference: both ordinals, each day checked against the next year
         5'd16: w = '{SEQ_CALL,   COND_ALWAYS,     OP_NOP,     UA_DB};
         5'd17: w = '{SEQ_NEXT,   COND_ALWAYS,     OP_ORD_A,   UA_START};
         5'd18: w = '{SEQ_CALL,   COND_ALWAYS,     OP_YR_A1,   UA_DB};
         5'd19: w = '{SEQ_BRANCH, COND_ORD_GE_ACC, OP_NOP,     UA_ERR};
         5'd20: w = '{SEQ_CALL,   COND_ALWAYS,     OP_YR_B,    UA_DB};
         5'd21: w = '{SEQ_NEXT,   COND_ALWAYS,     OP_AUX_B,   UA_START};
         5'd22: w = '{SEQ_CALL,   COND_ALWAYS,     OP_YR_B1,   UA_DB};
         5'd23: w = '{SEQ_BRANCH, COND_AUX_GE_ACC, OP_NOP,     UA_ERR};
         5'd24: w = '{SEQ_DONE,   COND_ALWAYS,     OP_CNT,     UA_START};
         // days before year yr
         5'd25: w = '{SEQ_NEXT,   COND_ALWAYS,     OP_DB_365,  UA_START};
         5'd26: w = '{SEQ_NEXT,   COND_ALWAYS,     OP_DB_4,    UA_START};
         5'd27: w = '{SEQ_NEXT,   COND_ALWAYS,     OP_DB_M100, UA_START};
         5'd28: w = '{SEQ_NEXT,   COND_ALWAYS,     OP_DB_S100, UA_START};
         5'd29: w = '{SEQ_NEXT,   COND_ALWAYS,     OP_DB_M400, UA_START};
         5'd30: w = '{SEQ_RET,    COND_ALWAYS,     OP_DB_A400, UA_START};
         default: w = '{SEQ_DONE, COND_ALWAYS,     OP_SET_ERR, UA_START};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/ordinal_date_add_and_diff_unit.sv @@
// Ordinal date arithmetic unit: microcoded sum and difference of ordinal dates
//
//   channel  ports                          transfer
//   ------   -----------------------------  -------------------------------
//   request  start, busy, req_*             start high while busy is low
//   result   rsp_strobe, rsp_*              rsp_strobe high, one cycle only
//
// A sum probes year by year from its estimate to the result year, and ends
// early when the sum leaves the year range. Each year probe runs the
// six-step days-before-year routine of the sequencer.
// busy stays high from the transfer until the cycle of the strobe.
// Reset is synchronous and clears the sequencer and the strobe; the receiver
// cannot stall, so no result ever waits.
`default_nettype none

`include "ordinal_date_add_and_diff_unit_defines.svh"

module ordinal_date_add_and_diff_unit (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    start,
   output logic                                   busy,
   input  wire                                    req_action,
   input  wire  [odad_pkg::YEAR_W-1:0]            req_year_a,
   input  wire  [odad_pkg::DAY_W-1:0]             req_day_a,
   input  wire  [odad_pkg::YEAR_W-1:0]            req_year_b,
   input  wire  [odad_pkg::DAY_W-1:0]             req_day_b,
   input  wire  signed [odad_pkg::OFF_W-1:0]      req_day_offset,
   output logic                                   rsp_strobe,
   output logic [odad_pkg::YEAR_W-1:0]            rsp_result_year,
   output logic [odad_pkg::DAY_W-1:0]             rsp_result_day,
   output logic signed [odad_pkg::CNT_W-1:0]      rsp_day_count,
   output logic                                   rsp_error
);

   // Sequencer state
   logic                              run_ff,    run_in;
   logic [odad_pkg::PC_W-1:0]         pc_ff,     pc_in;
   logic [odad_pkg::PC_W-1:0]         ret_ff,    ret_in;
   logic                              strobe_ff, strobe_in;

   // Captured request
   logic                              act_ff,    act_in;
   logic [odad_pkg::YEAR_W-1:0]       ya_ff,     ya_in;
   logic [odad_pkg::DAY_W-1:0]        da_ff,     da_in;
   logic [odad_pkg::YEAR_W-1:0]       yb_ff,     yb_in;
   logic [odad_pkg::DAY_W-1:0]        db_ff,     db_in;
   logic signed [odad_pkg::OFF_W-1:0] off_ff,    off_in;

   // Datapath registers
   logic [odad_pkg::YR_W-1:0]         yr_ff,     yr_in;
   logic signed [odad_pkg::ORD_W-1:0] acc_ff,    acc_in;
   logic signed [odad_pkg::ORD_W-1:0] ord_ff,    ord_in;
   logic signed [odad_pkg::ORD_W-1:0] aux_ff,    aux_in;
   logic [odad_pkg::PRD_W-1:0]        prd_ff,    prd_in;

   // Result registers
   logic [odad_pkg::YEAR_W-1:0]       ryear_ff,  ryear_in;
   logic [odad_pkg::DAY_W-1:0]        rday_ff,   rday_in;
   logic [odad_pkg::CNT_W-1:0]        cnt_ff,    cnt_in;
   logic                              err_ff,    err_in;

   // Combinational helpers
   odad_pkg::ucode_type               cw;
   logic                              cond_hit;
   logic                              accept;
   logic [odad_pkg::YR_W-1:0]         yr_p3;
   logic [odad_pkg::YR_W-1:0]         yr_p99;
   logic [odad_pkg::YR_W-1:0]         yr_p399;
   logic [odad_pkg::YR_W-1:0]         yr_est;
   logic [24:0]                       mul365;
   logic signed [odad_pkg::ORD_W-1:0] off_ext;
   logic signed [odad_pkg::ORD_W-1:0] day_diff;
   logic signed [odad_pkg::ORD_W-1:0] cnt_diff;
   logic signed [odad_pkg::ORD_W-1:0] quot25;

   assign accept   = start && !run_ff;
   assign cw       = odad_pkg::ucode_word(pc_ff);
   assign yr_p3    = yr_ff + 16'd3;
   assign yr_p99   = yr_ff + 16'd99;
   assign yr_p399  = yr_ff + 16'd399;
   assign yr_est   = prd_ff[odad_pkg::EST_SHIFT +: odad_pkg::YR_W];
   assign mul365   = 25'(yr_ff) * 25'(odad_pkg::YEAR_DAYS);
   assign off_ext  = odad_pkg::ORD_W'(off_ff);
   assign day_diff = ord_ff - acc_ff;
   assign cnt_diff = ord_ff - aux_ff;
   assign quot25   = $signed({17'd0, prd_ff[odad_pkg::DIV25_SHIFT +: 10]});

   // Evaluate the branch condition of the current control word
   always_comb begin
      case (cw.cond)
         odad_pkg::COND_ALWAYS:     cond_hit = 1'b1;
         odad_pkg::COND_DIFF:       cond_hit = act_ff;
         odad_pkg::COND_ORD_NEG:    cond_hit = ord_ff[odad_pkg::ORD_W-1];
         odad_pkg::COND_ORD_HIGH:   cond_hit = (ord_ff >= odad_pkg::DAYS_LIMIT);
         odad_pkg::COND_ORD_GE_ACC: cond_hit = (ord_ff >= acc_ff);
         odad_pkg::COND_AUX_GE_ACC: cond_hit = (aux_ff >= acc_ff);
         odad_pkg::COND_STAY:       cond_hit = (acc_ff <= ord_ff) || (yr_ff == '0);
         odad_pkg::COND_YR_TOP:     cond_hit = (yr_ff == odad_pkg::YEAR_TOP);
         odad_pkg::COND_ACC_LE_ORD: cond_hit = (acc_ff <= ord_ff);
         default:                   cond_hit = 1'b0;
      endcase
   end

   // Next-state logic: capture on transfer, else run one control word
   always_comb begin
      run_in    = run_ff;
      pc_in     = pc_ff;
      ret_in    = ret_ff;
      strobe_in = 1'b0;
      act_in    = act_ff;
      ya_in     = ya_ff;
      da_in     = da_ff;
      yb_in     = yb_ff;
      db_in     = db_ff;
      off_in    = off_ff;
      yr_in     = yr_ff;
      acc_in    = acc_ff;
      ord_in    = ord_ff;
      aux_in    = aux_ff;
      prd_in    = prd_ff;
      ryear_in  = ryear_ff;
      rday_in   = rday_ff;
      cnt_in    = cnt_ff;
      err_in    = err_ff;

      if (accept) begin
         run_in   = 1'b1;
         pc_in    = odad_pkg::UA_START;
         act_in   = req_action;
         ya_in    = req_year_a;
         da_in    = req_day_a;
         yb_in    = req_year_b;
         db_in    = req_day_b;
         off_in   = req_day_offset;
         ryear_in = '0;
         rday_in  = '0;
         cnt_in   = '0;
         err_in   = 1'b0;
      end else if (run_ff) begin
         // datapath operation
         case (cw.op)
            odad_pkg::OP_NOP:     ;
            odad_pkg::OP_YR_A:    yr_in = odad_pkg::YR_W'(ya_ff);
            odad_pkg::OP_YR_A1:   yr_in = odad_pkg::YR_W'(ya_ff) + 16'd1;
            odad_pkg::OP_YR_B:    yr_in = odad_pkg::YR_W'(yb_ff);
            odad_pkg::OP_YR_B1:   yr_in = odad_pkg::YR_W'(yb_ff) + 16'd1;
            odad_pkg::OP_YR_INC:  yr_in = yr_ff + 16'd1;
            odad_pkg::OP_YR_DEC:  yr_in = yr_ff - 16'd1;
            odad_pkg::OP_YR_EST:
               yr_in = (yr_est > odad_pkg::YEAR_TOP) ? odad_pkg::YEAR_TOP : yr_est;
            odad_pkg::OP_EST_MUL:
               prd_in = odad_pkg::PRD_W'(ord_ff[23:0]) * odad_pkg::PRD_W'(odad_pkg::EST_RECIP);
            odad_pkg::OP_DB_365:  acc_in = $signed({2'b00, mul365});
            odad_pkg::OP_DB_4:    acc_in = acc_ff + $signed({13'd0, yr_p3[15:2]});
            odad_pkg::OP_DB_M100:
               prd_in = odad_pkg::PRD_W'(yr_p99[15:2]) * odad_pkg::PRD_W'(odad_pkg::DIV25_RECIP);
            odad_pkg::OP_DB_S100: acc_in = acc_ff - quot25;
            odad_pkg::OP_DB_M400:
               prd_in = odad_pkg::PRD_W'(yr_p399[15:4]) * odad_pkg::PRD_W'(odad_pkg::DIV25_RECIP);
            odad_pkg::OP_DB_A400: acc_in = acc_ff + quot25;
            odad_pkg::OP_ORD_A:   ord_in = acc_ff + $signed({18'd0, da_ff});
            odad_pkg::OP_ORD_OFF: ord_in = ord_ff + off_ext;
            odad_pkg::OP_AUX_B:   aux_in = acc_ff + $signed({18'd0, db_ff});
            odad_pkg::OP_SET_ERR: err_in = 1'b1;
            odad_pkg::OP_CNT:     cnt_in = cnt_diff[odad_pkg::CNT_W-1:0];
            odad_pkg::OP_DAY: begin
               ryear_in = yr_ff[odad_pkg::YEAR_W-1:0];
               rday_in  = day_diff[odad_pkg::DAY_W-1:0];
            end
            default: ;
         endcase

         // sequencing
         case (cw.seq)
            odad_pkg::SEQ_NEXT:   pc_in = pc_ff + 5'd1;
            odad_pkg::SEQ_BRANCH: pc_in = cond_hit ? cw.target : pc_ff + 5'd1;
            odad_pkg::SEQ_CALL: begin
               pc_in  = cw.target;
               ret_in = pc_ff + 5'd1;
            end
            odad_pkg::SEQ_RET:    pc_in = ret_ff;
            odad_pkg::SEQ_DONE: begin
               run_in    = 1'b0;
               strobe_in = 1'b1;
            end
            default:              pc_in = pc_ff + 5'd1;
         endcase
      end
   end

   // Hold sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         pc_ff     <= odad_pkg::UA_START;
         strobe_ff <= 1'b0;
      end else begin
         run_ff    <= run_in;
         pc_ff     <= pc_in;
         strobe_ff <= strobe_in;
      end
   end

   // Advance datapath and result registers
   always_ff @(posedge clock) begin
      ret_ff   <= ret_in;
      act_ff   <= act_in;
      ya_ff    <= ya_in;
      da_ff    <= da_in;
      yb_ff    <= yb_in;
      db_ff    <= db_in;
      off_ff   <= off_in;
      yr_ff    <= yr_in;
      acc_ff   <= acc_in;
      ord_ff   <= ord_in;
      aux_ff   <= aux_in;
      prd_ff   <= prd_in;
      ryear_ff <= ryear_in;
      rday_ff  <= rday_in;
      cnt_ff   <= cnt_in;
      err_ff   <= err_in;
   end

   // Drive ports
   assign busy            = run_ff;
   assign rsp_strobe      = strobe_ff;
   assign rsp_result_year = ryear_ff;
   assign rsp_result_day  = rday_ff;
   assign rsp_day_count   = $signed(cnt_ff);
   assign rsp_error       = err_ff;

   // Checks
   logic sum_zero;
   logic cnt_zero;
   logic fields_zero;
   logic day_ok;

   assign sum_zero    = (rsp_result_year == '0) && (rsp_result_day == '0);
   assign cnt_zero    = (rsp_day_count == '0);
   assign fields_zero = sum_zero && cnt_zero;
   assign day_ok      = (rsp_result_day <= odad_pkg::MAX_DAY);

   `ODAD_ASSERT_NOW(a_strobe_idle, rsp_strobe, !busy, "result strobe while still busy")
   `ODAD_ASSERT_NEXT(a_start_runs, start && !busy, busy, "transfer did not start the sequencer")
   `ODAD_ASSERT_NOW(a_err_zero, rsp_strobe && rsp_error, fields_zero, "error result not zeroed")
   `ODAD_ASSERT_NOW(a_day_legal, rsp_strobe && !rsp_error, day_ok, "result day beyond the year")
   `ODAD_ASSERT_NOW(a_one_path, rsp_strobe && !cnt_zero, sum_zero, "both result kinds set")

endmodule

`default_nettype wire
